// File: design/locd_pkg.sv
// Shared types and constants for the LRU object cache directory.
package locd_pkg;

	localparam int KEY_W   = 48;
	localparam int SIZE_W  = 21;
	localparam int IN_W    = 72;
	localparam int OUT_W   = 8;
	localparam int LINE_W  = 4;
	localparam int STAMP_W = 32;

	localparam logic [SIZE_W-1:0] LIMIT_RESET = 21'd102400;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH,
		ST_SCAN,
		ST_WRITE,
		ST_DONE
	} locd_state_t;

	typedef struct packed {
		logic              replaced;
		logic              stored;
		logic [LINE_W-1:0] line;
		logic              hit;
	} locd_result_t;

endpackage

// File: design/locd_ram.sv
// Generic single-port synchronous RAM with a registered read.
module locd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// File: design/lru_object_cache_directory.sv
// Top level of the LRU object cache directory: control sequencer around tag and stamp RAMs.
//
// Each input word on s_* carries a key and the byte size of the fetched object. The block
// looks the key up among the filled lines and returns one result word on m_* per request:
// hit flag, line number, stored flag and replaced flag. cfg_we with cfg_wdata sets the size
// limit; objects of that size or larger are never stored. Write it only while the block is idle.
// One request is handled at a time. The tag RAM is walked one line per cycle to look for a hit,
// and a miss with every line full also walks the stamp RAM one line per cycle to find the
// oldest line. The block returns to idle and accepts the next request once the result
// register loads. The single port of each RAM is why each walk reads one line at a time.
// Reset empties the directory, clears the use clock and restores the default size limit.
// The RAMs need no clearing pass. A finished result waits in the output register while the
// next request is taken in; if the receiver still stalls when the next result is ready, the
// block holds that result until the register frees.
module lru_object_cache_directory #(
	parameter int LINES    = 10,
	parameter int KEY_BITS = 48
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [locd_pkg::SIZE_W-1:0] cfg_wdata,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [locd_pkg::IN_W-1:0]   s_tdata,   // key[47:0], object_size[68:48], zero fill
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [locd_pkg::OUT_W-1:0]  m_tdata    // hit, line[3:0], stored, replaced, zero fill
);

	import locd_pkg::*;

	localparam int IW = $clog2(LINES);
	localparam int CW = $clog2(LINES + 1);
	localparam logic [CW-1:0] LINES_C = CW'(LINES);

	locd_state_t         state_q, state_d;
	logic [CW-1:0]       rd_idx_q, rd_idx_d;
	logic                pend_q, pend_d;
	logic [IW-1:0]       cmp_idx_q, cmp_idx_d;
	logic [IW-1:0]       best_q, best_d;
	logic [STAMP_W-1:0]  best_stamp_q, best_stamp_d;
	logic                first_q, first_d;
	logic [KEY_BITS-1:0] key_q, key_d;
	logic [SIZE_W-1:0]   size_q, size_d;
	logic [IW-1:0]       slot_q, slot_d;
	logic                hit_q, hit_d;
	logic                stored_q, stored_d;
	logic                repl_q, repl_d;
	logic [CW-1:0]       fill_q, fill_d;
	logic [STAMP_W-1:0]  clock_q, clock_d;
	logic [SIZE_W-1:0]   max_q;
	locd_result_t        out_q;
	logic                out_valid_q;
	logic                out_load;

	logic                tag_we, stamp_we;
	logic [IW-1:0]       ram_addr;
	logic [KEY_BITS-1:0] tag_rdata;
	logic [STAMP_W-1:0]  stamp_rdata;
	logic [63:0]         key_wide;
	logic                match;
	logic                older;
	logic [IW-1:0]       cand_idx;
	logic [STAMP_W-1:0]  cand_stamp;

	assign key_wide = {{(64 - KEY_W){1'b0}}, s_tdata[KEY_W-1:0]};
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q};

	assign match      = pend_q && (tag_rdata == key_q);
	assign older      = pend_q && (first_q || (stamp_rdata < best_stamp_q));
	assign cand_idx   = older ? cmp_idx_q : best_q;
	assign cand_stamp = older ? stamp_rdata : best_stamp_q;

	locd_ram #(.WIDTH(KEY_BITS), .DEPTH(LINES)) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.addr  (ram_addr),
		.wdata (key_q),
		.rdata (tag_rdata)
	);

	locd_ram #(.WIDTH(STAMP_W), .DEPTH(LINES)) u_stamp_ram (
		.clk   (clk),
		.we    (stamp_we),
		.addr  (ram_addr),
		.wdata (clock_q),
		.rdata (stamp_rdata)
	);

	always_comb begin
		state_d      = state_q;
		rd_idx_d     = rd_idx_q;
		pend_d       = pend_q;
		cmp_idx_d    = cmp_idx_q;
		best_d       = best_q;
		best_stamp_d = best_stamp_q;
		first_d      = first_q;
		key_d        = key_q;
		size_d       = size_q;
		slot_d       = slot_q;
		hit_d        = hit_q;
		stored_d     = stored_q;
		repl_d       = repl_q;
		fill_d       = fill_q;
		clock_d      = clock_q;
		tag_we       = 1'b0;
		stamp_we     = 1'b0;
		ram_addr     = rd_idx_q[IW-1:0];
		out_load     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					key_d    = key_wide[KEY_BITS-1:0];
					size_d   = s_tdata[KEY_W +: SIZE_W];
					rd_idx_d = '0;
					pend_d   = 1'b0;
					slot_d   = '0;
					hit_d    = 1'b0;
					stored_d = 1'b0;
					repl_d   = 1'b0;
					state_d  = ST_SRCH;
				end
			end
			ST_SRCH: begin
				if (match) begin
					hit_d   = 1'b1;
					slot_d  = cmp_idx_q;
					pend_d  = 1'b0;
					state_d = ST_WRITE;
				end else if (rd_idx_q < fill_q) begin
					pend_d    = 1'b1;
					cmp_idx_d = rd_idx_q[IW-1:0];
					rd_idx_d  = rd_idx_q + 1'b1;
				end else begin
					pend_d = 1'b0;
					if (size_q >= max_q) begin
						state_d = ST_DONE;
					end else if (fill_q < LINES_C) begin
						slot_d   = fill_q[IW-1:0];
						stored_d = 1'b1;
						state_d  = ST_WRITE;
					end else begin
						rd_idx_d = '0;
						first_d  = 1'b1;
						state_d  = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				best_d       = cand_idx;
				best_stamp_d = cand_stamp;
				if (pend_q) begin
					first_d = 1'b0;
				end
				if (rd_idx_q < LINES_C) begin
					pend_d    = 1'b1;
					cmp_idx_d = rd_idx_q[IW-1:0];
					rd_idx_d  = rd_idx_q + 1'b1;
				end else begin
					pend_d   = 1'b0;
					slot_d   = cand_idx;
					stored_d = 1'b1;
					repl_d   = 1'b1;
					state_d  = ST_WRITE;
				end
			end
			ST_WRITE: begin
				ram_addr = slot_q;
				stamp_we = 1'b1;
				tag_we   = stored_q;
				clock_d  = clock_q + 1'b1;
				if (stored_q && !repl_q) begin
					fill_d = fill_q + 1'b1;
				end
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_q      <= 1'b0;
			fill_q      <= '0;
			clock_q     <= '0;
			max_q       <= LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
			fill_q  <= fill_d;
			clock_q <= clock_d;
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_q     <= rd_idx_d;
		cmp_idx_q    <= cmp_idx_d;
		best_q       <= best_d;
		best_stamp_q <= best_stamp_d;
		first_q      <= first_d;
		key_q        <= key_d;
		size_q       <= size_d;
		slot_q       <= slot_d;
		hit_q        <= hit_d;
		stored_q     <= stored_d;
		repl_q       <= repl_d;
		if (out_load) begin
			out_q.hit      <= hit_q;
			out_q.line     <= LINE_W'(slot_q);
			out_q.stored   <= stored_q;
			out_q.replaced <= repl_q;
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LINES_C)
		else $error("fill count exceeds the number of lines");

	a_clock_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |=> (clock_q == $past(clock_q) + 1'b1))
		else $error("use clock did not advance after a stamp write");

	a_clock_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_WRITE) |=> (clock_q == $past(clock_q)))
		else $error("use clock moved without a stamp write");

	a_replace_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && repl_q) |-> (fill_q == LINES_C))
		else $error("replacement reported while free lines remain");

	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !(hit_q && stored_q) && !(repl_q && !stored_q))
		else $error("inconsistent result flags");
`endif

endmodule
